// File: hdl/bahr_pkg.sv
// Shared constants, codes and types of the bucket average history ring.
package bahr_pkg;

   localparam int METRICS       = 6;
   localparam int HISTORY_SLOTS = 60;
   localparam int SAMPLE_BITS   = 32;

   localparam int VALUE_W  = 32;
   localparam int SUM_W    = 48;
   localparam int COUNT_W  = 16;
   localparam int TICK_W   = 24;
   localparam int OP_W     = 2;
   localparam int METRIC_W = 3;
   localparam int AGE_W    = 6;
   localparam int FILL_W   = 6;

   localparam int COUNT_MAX   = 2 ** COUNT_W - 1;
   localparam int TICKS_RESET = 60000;

   localparam int MIDX_W    = (METRICS > 1) ? $clog2(METRICS) : 1;
   localparam int SLOT_W    = $clog2(HISTORY_SLOTS);
   localparam int STORED_W  = $clog2(HISTORY_SLOTS + 1);
   localparam int MEM_DEPTH = METRICS * HISTORY_SLOTS;
   localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
   localparam int ENTRY_W   = VALUE_W + 1;
   localparam int RSUM_W    = $clog2(2 * HISTORY_SLOTS) + 1;
   localparam int CMP_W     = (STORED_W > AGE_W) ? STORED_W : AGE_W;
   localparam int STEP_W    = $clog2(SUM_W);

   localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
   localparam logic [OP_W-1:0] OP_TICK   = 2'd1;
   localparam logic [OP_W-1:0] OP_READ   = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD,
      ST_READ_ADDR,
      ST_READ_DATA,
      ST_CLOSE_SCAN,
      ST_CLOSE_DIV,
      ST_CLOSE_END,
      ST_REPLY
   } seq_state_type;

   typedef struct packed {
      logic              add;
      logic              clear;
      logic [MIDX_W-1:0] index;
   } acc_ctrl_type;

endpackage

// File: hdl/bahr_accum.sv
// Per-metric running sums and saturating sample counts.
module bahr_accum
   import bahr_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  acc_ctrl_type             ctrl,
   input  logic signed [VALUE_W-1:0] sample_value,
   output logic signed [SUM_W-1:0]  sum,
   output logic [COUNT_W-1:0]       count
);

   logic signed [SUM_W-1:0] sum_ff [METRICS];
   logic signed [SUM_W-1:0] sum_in [METRICS];
   logic [COUNT_W-1:0]      cnt_ff [METRICS];
   logic [COUNT_W-1:0]      cnt_in [METRICS];
   logic [SUM_W-1:0]        raw;
   logic [SUM_W-1:0]        ext;

   // sign-extend the low SAMPLE_BITS bits of the sample
   always_comb begin
      raw = SUM_W'(unsigned'(sample_value));
      for (int i = 0; i < SUM_W; i++) begin
         ext[i] = (i < SAMPLE_BITS) ? raw[i] : raw[SAMPLE_BITS-1];
      end
   end

   always_comb begin
      sum_in = sum_ff;
      cnt_in = cnt_ff;
      if (ctrl.clear) begin
         sum_in[ctrl.index] = '0;
         cnt_in[ctrl.index] = '0;
      end else if (ctrl.add && cnt_ff[ctrl.index] != COUNT_W'(COUNT_MAX)) begin
         sum_in[ctrl.index] = sum_ff[ctrl.index] + signed'(ext);
         cnt_in[ctrl.index] = cnt_ff[ctrl.index] + COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int m = 0; m < METRICS; m++) begin
            sum_ff[m] <= '0;
            cnt_ff[m] <= '0;
         end
      end else begin
         sum_ff <= sum_in;
         cnt_ff <= cnt_in;
      end
   end

   assign sum   = sum_ff[ctrl.index];
   assign count = cnt_ff[ctrl.index];

endmodule

// File: hdl/bahr_divider.sv
// Shared restoring divider: signed sum by unsigned count, one bit per cycle.
module bahr_divider
   import bahr_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic signed [SUM_W-1:0]   dividend,
   input  logic [COUNT_W-1:0]        divisor,
   output logic                      done,
   output logic signed [VALUE_W-1:0] quotient
);

   localparam logic [SUM_W-1:0] POS_LIMIT =
      {{(SUM_W - VALUE_W + 1){1'b0}}, {(VALUE_W - 1){1'b1}}};
   localparam logic [SUM_W-1:0] NEG_LIMIT = POS_LIMIT + SUM_W'(1);

   logic                busy_ff, busy_in;
   logic                fin_ff, fin_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic                neg_ff, neg_in;
   logic [SUM_W-1:0]    dq_ff, dq_in;
   logic [COUNT_W-1:0]  rem_ff, rem_in;
   logic [COUNT_W-1:0]  dvs_ff, dvs_in;
   logic [VALUE_W-1:0]  quot_ff, quot_in;
   logic [COUNT_W:0]    shifted;
   logic [COUNT_W:0]    diff;
   logic [SUM_W-1:0]    neg_mag;

   always_comb begin
      busy_in = busy_ff;
      fin_in  = 1'b0;
      done_in = 1'b0;
      step_in = step_ff;
      neg_in  = neg_ff;
      dq_in   = dq_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quot_in = quot_ff;
      shifted = {rem_ff, dq_ff[SUM_W-1]};
      diff    = shifted - {1'b0, dvs_ff};
      neg_mag = ~dq_ff + SUM_W'(1);
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         neg_in  = dividend[SUM_W-1];
         dq_in   = dividend[SUM_W-1] ? (~unsigned'(dividend) + SUM_W'(1))
                                     : unsigned'(dividend);
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (!diff[COUNT_W]) begin
            rem_in = diff[COUNT_W-1:0];
         end else begin
            rem_in = shifted[COUNT_W-1:0];
         end
         dq_in   = {dq_ff[SUM_W-2:0], !diff[COUNT_W]};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(SUM_W - 1)) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end else if (fin_ff) begin
         // sign and clamp into the value range
         done_in = 1'b1;
         if (neg_ff) begin
            quot_in = (dq_ff > NEG_LIMIT) ? NEG_LIMIT[VALUE_W-1:0]
                                          : neg_mag[VALUE_W-1:0];
         end else begin
            quot_in = (dq_ff > POS_LIMIT) ? POS_LIMIT[VALUE_W-1:0]
                                          : dq_ff[VALUE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff  <= neg_in;
      dq_ff   <= dq_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      quot_ff <= quot_in;
   end

   assign done     = done_ff;
   assign quotient = signed'(quot_ff);

endmodule

// File: hdl/bucket_average_history_ring_core.sv
// Top level: per-metric bucket averager with a ring of past bucket averages.
//
// Each request is one of three operations. A sample adds its value to the
// running sum of its metric and bumps that metric's count (the count sticks
// at 65535, invalid samples and metrics out of range are ignored). A tick
// advances the tick counter; when csr_bucket_ticks ticks have gone by (zero
// counts as one) the bucket closes: every metric's sum is divided by its
// count, truncating toward zero and clamped to the 32-bit signed range, and
// written into the ring slot at the write position, or a gap if the metric
// saw no samples; sums and counts then clear, the write position advances
// and the fill count grows up to the number of slots. A read returns the
// slot of one metric at an age counted from the oldest stored bucket, or a
// gap if the age is not yet stored or the metric is out of range. Every
// request gives exactly one response, which carries the fill count after
// the request and a flag for a tick that closed a bucket.
// Handshake: one request at a time, req_ready is high only while idle.
// A closing tick is paced by the single shared divider, which retires
// one quotient bit per cycle over 48 bits for each metric with samples;
// an empty metric only writes a gap. The response register lets a new
// request be taken while the previous response still waits for rsp_ready.
// The ring is a 360 x 33 memory (value plus present bit) with one write and
// one registered read port; it needs no clearing, since a read only reaches
// slots that a bucket close has written. csr_ready is always high and the
// register may be written only while the block is idle.
module bucket_average_history_ring_core
   import bahr_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   // configuration write
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [TICK_W-1:0]         csr_bucket_ticks,
   // request channel
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [OP_W-1:0]           req_operation,
   input  logic [METRIC_W-1:0]       req_metric,
   input  logic signed [VALUE_W-1:0] req_sample_value,
   input  logic                      req_sample_valid,
   input  logic [AGE_W-1:0]          req_read_age,
   // response channel
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [VALUE_W-1:0] rsp_slot_value,
   output logic                      rsp_slot_present,
   output logic [FILL_W-1:0]         rsp_filled_count,
   output logic                      rsp_bucket_closed
);

   // sequencer and bookkeeping state
   seq_state_type        state_ff, state_in;
   logic [TICK_W-1:0]    ticks_cfg_ff, ticks_cfg_in;
   logic [TICK_W-1:0]    tick_ff, tick_in;
   logic [SLOT_W-1:0]    wp_ff, wp_in;
   logic [STORED_W-1:0]  stored_ff, stored_in;
   logic [MIDX_W-1:0]    idx_ff, idx_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // latched request and pending result
   logic [METRIC_W-1:0]       metric_ff, metric_in;
   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic                      svalid_ff, svalid_in;
   logic [AGE_W-1:0]          age_ff, age_in;
   logic                      hit_ff, hit_in;
   logic [VALUE_W-1:0]        res_value_ff, res_value_in;
   logic                      res_present_ff, res_present_in;
   logic                      res_closed_ff, res_closed_in;
   logic [VALUE_W-1:0]        rsp_value_ff, rsp_value_in;
   logic                      rsp_present_ff, rsp_present_in;
   logic [FILL_W-1:0]         rsp_fill_ff, rsp_fill_in;
   logic                      rsp_closed_ff, rsp_closed_in;

   // ring memory
   logic [ENTRY_W-1:0] hist_mem [MEM_DEPTH];
   logic [ENTRY_W-1:0] mem_rd_ff;
   logic               mem_we;
   logic [ADDR_W-1:0]  mem_waddr;
   logic [ENTRY_W-1:0] mem_wdata;
   logic [ADDR_W-1:0]  mem_raddr;

   // datapath helpers
   acc_ctrl_type              acc_ctrl;
   logic signed [SUM_W-1:0]   acc_sum;
   logic [COUNT_W-1:0]        acc_count;
   logic                      div_start;
   logic                      div_done;
   logic signed [VALUE_W-1:0] div_quot;
   logic                      out_free;
   logic [TICK_W-1:0]         tick_limit;
   logic [TICK_W-1:0]         tick_next;
   logic                      metric_ok;
   logic [RSUM_W-1:0]         ring_sum;
   logic [SLOT_W-1:0]         ring_slot;
   logic                      last_metric;

   bahr_accum u_accum (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (acc_ctrl),
      .sample_value (value_ff),
      .sum          (acc_sum),
      .count        (acc_count)
   );

   bahr_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (acc_sum),
      .divisor  (acc_count),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign tick_limit  = (ticks_cfg_ff == '0) ? TICK_W'(1) : ticks_cfg_ff;
   assign tick_next   = tick_ff + TICK_W'(1);
   assign metric_ok   = int'(metric_ff) < METRICS;
   assign last_metric = idx_ff == MIDX_W'(METRICS - 1);

   // ring position of the requested age; stays below twice the slot count for a stored age
   always_comb begin
      ring_sum = RSUM_W'(wp_ff) + RSUM_W'(HISTORY_SLOTS) - RSUM_W'(stored_ff)
               + RSUM_W'(age_ff);
      if (ring_sum >= RSUM_W'(HISTORY_SLOTS)) begin
         ring_slot = SLOT_W'(ring_sum - RSUM_W'(HISTORY_SLOTS));
      end else begin
         ring_slot = SLOT_W'(ring_sum);
      end
   end

   always_comb begin
      state_in       = state_ff;
      ticks_cfg_in   = ticks_cfg_ff;
      tick_in        = tick_ff;
      wp_in          = wp_ff;
      stored_in      = stored_ff;
      idx_in         = idx_ff;
      metric_in      = metric_ff;
      value_in       = value_ff;
      svalid_in      = svalid_ff;
      age_in         = age_ff;
      hit_in         = hit_ff;
      res_value_in   = res_value_ff;
      res_present_in = res_present_ff;
      res_closed_in  = res_closed_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_value_in   = rsp_value_ff;
      rsp_present_in = rsp_present_ff;
      rsp_fill_in    = rsp_fill_ff;
      rsp_closed_in  = rsp_closed_ff;
      req_ready      = 1'b0;
      acc_ctrl.add   = 1'b0;
      acc_ctrl.clear = 1'b0;
      acc_ctrl.index = MIDX_W'(metric_ff);
      div_start      = 1'b0;
      mem_we         = 1'b0;
      mem_waddr      = ADDR_W'(idx_ff) * ADDR_W'(HISTORY_SLOTS) + ADDR_W'(wp_ff);
      mem_wdata      = '0;
      mem_raddr      = '0;

      if (csr_valid) begin
         ticks_cfg_in = csr_bucket_ticks;
      end

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               metric_in      = req_metric;
               value_in       = req_sample_value;
               svalid_in      = req_sample_valid;
               age_in         = req_read_age;
               res_value_in   = '0;
               res_present_in = 1'b0;
               res_closed_in  = 1'b0;
               unique case (req_operation)
                  OP_SAMPLE: state_in = ST_ADD;
                  OP_READ:   state_in = ST_READ_ADDR;
                  OP_TICK: begin
                     // counter wrap also closes
                     if (tick_next >= tick_limit || tick_next == '0) begin
                        tick_in  = '0;
                        idx_in   = '0;
                        state_in = ST_CLOSE_SCAN;
                     end else begin
                        tick_in  = tick_next;
                        state_in = ST_REPLY;
                     end
                  end
                  default: state_in = ST_REPLY;
               endcase
            end
         end
         ST_ADD: begin
            acc_ctrl.add = svalid_ff && metric_ok;
            state_in     = ST_REPLY;
         end
         ST_READ_ADDR: begin
            hit_in = metric_ok && (CMP_W'(age_ff) < CMP_W'(stored_ff));
            if (metric_ok) begin
               mem_raddr = ADDR_W'(metric_ff) * ADDR_W'(HISTORY_SLOTS)
                         + ADDR_W'(ring_slot);
            end
            state_in = ST_READ_DATA;
         end
         ST_READ_DATA: begin
            if (hit_ff && mem_rd_ff[VALUE_W]) begin
               res_value_in   = mem_rd_ff[VALUE_W-1:0];
               res_present_in = 1'b1;
            end
            state_in = ST_REPLY;
         end
         ST_CLOSE_SCAN: begin
            acc_ctrl.index = idx_ff;
            if (acc_count != '0) begin
               div_start = 1'b1;
               state_in  = ST_CLOSE_DIV;
            end else begin
               // no samples: write a gap
               mem_we         = 1'b1;
               acc_ctrl.clear = 1'b1;
               if (last_metric) begin
                  state_in = ST_CLOSE_END;
               end else begin
                  idx_in = idx_ff + MIDX_W'(1);
               end
            end
         end
         ST_CLOSE_DIV: begin
            acc_ctrl.index = idx_ff;
            if (div_done) begin
               mem_we         = 1'b1;
               mem_wdata      = {1'b1, unsigned'(div_quot)};
               acc_ctrl.clear = 1'b1;
               if (last_metric) begin
                  state_in = ST_CLOSE_END;
               end else begin
                  idx_in   = idx_ff + MIDX_W'(1);
                  state_in = ST_CLOSE_SCAN;
               end
            end
         end
         ST_CLOSE_END: begin
            wp_in = (wp_ff == SLOT_W'(HISTORY_SLOTS - 1)) ? '0 : wp_ff + SLOT_W'(1);
            if (stored_ff < STORED_W'(HISTORY_SLOTS)) begin
               stored_in = stored_ff + STORED_W'(1);
            end
            res_closed_in = 1'b1;
            state_in      = ST_REPLY;
         end
         ST_REPLY: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_value_in   = res_value_ff;
               rsp_present_in = res_present_ff;
               rsp_fill_in    = FILL_W'(stored_ff);
               rsp_closed_in  = res_closed_ff;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ticks_cfg_ff <= TICK_W'(TICKS_RESET);
         tick_ff      <= '0;
         wp_ff        <= '0;
         stored_ff    <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ticks_cfg_ff <= ticks_cfg_in;
         tick_ff      <= tick_in;
         wp_ff        <= wp_in;
         stored_ff    <= stored_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      metric_ff      <= metric_in;
      value_ff       <= value_in;
      svalid_ff      <= svalid_in;
      age_ff         <= age_in;
      hit_ff         <= hit_in;
      res_value_ff   <= res_value_in;
      res_present_ff <= res_present_in;
      res_closed_ff  <= res_closed_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_present_ff <= rsp_present_in;
      rsp_fill_ff    <= rsp_fill_in;
      rsp_closed_ff  <= rsp_closed_in;
   end

   // ring memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         hist_mem[mem_waddr] <= mem_wdata;
      end
      mem_rd_ff <= hist_mem[mem_raddr];
   end

   assign csr_ready         = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_slot_value    = signed'(rsp_value_ff);
   assign rsp_slot_present  = rsp_present_ff;
   assign rsp_filled_count  = rsp_fill_ff;
   assign rsp_bucket_closed = rsp_closed_ff;

endmodule
